[rtl/rgfc_pkg.sv]
// Package: shared types, result codes and frame layout for the roll gesture classifier.
`default_nettype none

package rgfc_pkg;

  // Result codes
  localparam logic [2:0] RES_SAMPLE     = 3'd0;
  localparam logic [2:0] RES_MISALIGNED = 3'd1;
  localparam logic [2:0] RES_NONE       = 3'd2;
  localparam logic [2:0] RES_LEFT       = 3'd3;
  localparam logic [2:0] RES_RIGHT      = 3'd4;

  // Frame layout
  localparam logic [7:0] HEADER_BYTE = 8'hAA;
  localparam int POS_HDR0    = 0;
  localparam int POS_HDR1    = 1;
  localparam int POS_ROLL_LO = 7;
  localparam int POS_ROLL_HI = 8;
  localparam int POS_AX_LO   = 9;
  localparam int POS_AX_HI   = 10;
  localparam int POS_AZ_LO   = 13;
  localparam int POS_AZ_HI   = 14;

  // Window limit
  localparam int         MAX_WINDOW = 63;
  localparam logic [7:0] MAX_WIN_W  = 8'(MAX_WINDOW);

  // Configuration register indexes
  localparam logic [1:0] CFG_ROLL_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LENGTH = 2'd1;

  localparam logic [14:0] ROLL_LIMIT_RST    = 15'd3500;
  localparam logic [5:0]  WINDOW_LENGTH_RST = 6'd25;

  // Frame fields as seen on the current byte beat
  typedef struct packed {
    logic        end_of_frame;
    logic        header_ok;
    logic [15:0] roll;
    logic [15:0] accel_x;
    logic [15:0] accel_z;
  } frame_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] roll;
    logic [15:0] accel_x;
    logic [15:0] accel_z;
    logic [5:0]  left_tally;
    logic [5:0]  right_tally;
  } result_t;

endpackage

`default_nettype wire

[rtl/rgfc_frame_asm.sv]
// Frame assembler: byte position, header check and field capture.
`default_nettype none

module rgfc_frame_asm import rgfc_pkg::*; #(
  parameter int FRAME_BYTES = 19
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       beat,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame
);

  localparam int PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] END_POS = PW'(FRAME_BYTES - 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          hdr_r, hdr_nxt;
  logic [15:0]   roll_r, roll_nxt;
  logic [15:0]   ax_r, ax_nxt;
  logic [15:0]   az_r, az_nxt;

  // Capture the byte into its field by position
  always_comb begin
    hdr_nxt  = hdr_r;
    roll_nxt = roll_r;
    ax_nxt   = ax_r;
    az_nxt   = az_r;
    unique case (pos_r)
      PW'(POS_HDR0):    hdr_nxt = (rx_byte == HEADER_BYTE);
      PW'(POS_HDR1):    hdr_nxt = hdr_r && (rx_byte == HEADER_BYTE);
      PW'(POS_ROLL_LO): roll_nxt = {roll_r[15:8], rx_byte};
      PW'(POS_ROLL_HI): roll_nxt = {rx_byte, roll_r[7:0]};
      PW'(POS_AX_LO):   ax_nxt = {ax_r[15:8], rx_byte};
      PW'(POS_AX_HI):   ax_nxt = {rx_byte, ax_r[7:0]};
      PW'(POS_AZ_LO):   az_nxt = {az_r[15:8], rx_byte};
      PW'(POS_AZ_HI):   az_nxt = {rx_byte, az_r[7:0]};
      default: ;
    endcase
    pos_nxt = (pos_r >= END_POS) ? '0 : pos_r + 1'b1;
  end

  // Advance on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hdr_r  <= 1'b0;
      roll_r <= '0;
      ax_r   <= '0;
      az_r   <= '0;
    end else if (beat) begin
      pos_r  <= pos_nxt;
      hdr_r  <= hdr_nxt;
      roll_r <= roll_nxt;
      ax_r   <= ax_nxt;
      az_r   <= az_nxt;
    end
  end

  // Fields include the current byte, so a late field byte on the frame end counts
  assign frame.end_of_frame = (pos_r >= END_POS);
  assign frame.header_ok    = hdr_nxt;
  assign frame.roll         = roll_nxt;
  assign frame.accel_x      = ax_nxt;
  assign frame.accel_z      = az_nxt;

endmodule

`default_nettype wire

[rtl/rgfc_classify.sv]
// Classifier: window sample counting, left/right tallies and gesture decision.
`default_nettype none

module rgfc_classify import rgfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        beat,
  input  wire frame_t      frame,
  input  wire logic [14:0] roll_limit,
  input  wire logic [5:0]  window_length,
  output result_t          result
);

  logic [5:0] sample_r, left_r, right_r;
  logic [5:0] sample_nxt, left_nxt, right_nxt;

  logic [7:0]         win;
  logic [7:0]         half;
  logic               full;
  logic signed [16:0] roll_s, lim_s;
  logic               is_left, is_right;

  // Clamp window and compare roll against the limit
  always_comb begin
    win      = ({2'b00, window_length} > MAX_WIN_W) ? MAX_WIN_W : {2'b00, window_length};
    half     = win >> 1;
    full     = ({2'b00, sample_r} >= win);
    roll_s   = {frame.roll[15], frame.roll};
    lim_s    = {2'b00, roll_limit};
    is_left  = (roll_s < -lim_s);
    is_right = (roll_s > lim_s);
  end

  // Build result and next counts
  always_comb begin
    sample_nxt = sample_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    result.roll        = frame.roll;
    result.accel_x     = frame.accel_x;
    result.accel_z     = frame.accel_z;
    result.left_tally  = left_r;
    result.right_tally = right_r;
    if (!frame.header_ok) begin
      result.event_res = RES_MISALIGNED;
      result.roll      = '0;
      result.accel_x   = '0;
      result.accel_z   = '0;
    end else if (full) begin
      if ({2'b00, left_r} >= half) begin
        result.event_res = RES_LEFT;
      end else if ({2'b00, right_r} >= half) begin
        result.event_res = RES_RIGHT;
      end else begin
        result.event_res = RES_NONE;
      end
      sample_nxt = '0;
      left_nxt   = '0;
      right_nxt  = '0;
    end else begin
      result.event_res = RES_SAMPLE;
      if (is_left) begin
        left_nxt = left_r + 1'b1;
      end else if (is_right) begin
        right_nxt = right_r + 1'b1;
      end
      sample_nxt = sample_r + 1'b1;
      result.left_tally  = left_nxt;
      result.right_tally = right_nxt;
    end
  end

  // Update counts on the frame-end beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      left_r   <= '0;
      right_r  <= '0;
    end else if (beat && frame.end_of_frame) begin
      sample_r <= sample_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/roll_gesture_frame_classifier.sv]
// Top level: configuration registers, frame assembler, classifier, result register.
// Result: a result is valid in the cycle after the beat of the last byte of a frame.
// Throughput: one byte per cycle; only a frame-end byte waits while an unread result
// is held in the result register, other bytes are taken regardless.
// Reset (synchronous, rst_n low): byte position, header flag, field holds and all
// counts clear; roll_limit returns to 3500 and window_length to 25.
`default_nettype none

module roll_gesture_frame_classifier import rgfc_pkg::*; #(
  parameter int FRAME_BYTES = 19
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_event_res,
  output logic signed [15:0]      out_roll_value,
  output logic signed [15:0]      out_accel_x,
  output logic signed [15:0]      out_accel_z,
  output logic [5:0]              out_left_tally,
  output logic [5:0]              out_right_tally,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata
);

  logic [14:0] roll_limit_r;
  logic [5:0]  window_length_r;
  logic        out_valid_r;
  result_t     res_r;
  frame_t      frame;
  result_t     result;
  logic        beat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roll_limit_r    <= ROLL_LIMIT_RST;
      window_length_r <= WINDOW_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROLL_LIMIT:    roll_limit_r <= cfg_wdata;
        CFG_WINDOW_LENGTH: window_length_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Hold a frame-end byte only while the result register is occupied and out_ready is low
  assign in_ready = !out_valid_r || out_ready || !frame.end_of_frame;
  assign beat     = in_valid && in_ready;

  rgfc_frame_asm #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .beat    (beat),
    .rx_byte (in_rx_byte),
    .frame   (frame)
  );

  rgfc_classify u_classify (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat          (beat),
    .frame         (frame),
    .roll_limit    (roll_limit_r),
    .window_length (window_length_r),
    .result        (result)
  );

  // Result register: load on frame end, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat && frame.end_of_frame) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat && frame.end_of_frame) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = res_r.event_res;
  assign out_roll_value  = $signed(res_r.roll);
  assign out_accel_x     = $signed(res_r.accel_x);
  assign out_accel_z     = $signed(res_r.accel_z);
  assign out_left_tally  = res_r.left_tally;
  assign out_right_tally = res_r.right_tally;

  // Assertions
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.event_res <= RES_RIGHT))
    else $error("result code out of range");

  a_misaligned_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.event_res == RES_MISALIGNED) |->
      (res_r.roll == 16'd0 && res_r.accel_x == 16'd0 && res_r.accel_z == 16'd0))
    else $error("misaligned result carries field data");

  a_result_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && frame.end_of_frame) |=> out_valid_r)
    else $error("frame end beat gave no result");

endmodule

`default_nettype wire
